// File: hw/rtl/aip_pkg.sv
package aip_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_AFTER_SIGN,
      PH_FIRST,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } digit_type;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam int BASE_WIDTH      = 6;
   localparam int OFFSET_OUT_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_SELECT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE = 1'd1;

   localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] LETTER_BIAS = 8'd10;

   function automatic digit_type char_digit(input logic [7:0] c);
      digit_type  d;
      logic [7:0] v;
      d.valid = 1'b1;
      v       = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         v = c - CH_LO_A + LETTER_BIAS;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         v = c - CH_UP_A + LETTER_BIAS;
      end else begin
         d.valid = 1'b0;
      end
      d.value = v[5:0];
      return d;
   endfunction

endpackage

// File: hw/rtl/ascii_integer_parser.sv
// Parses an integer from a character stream, one character per transfer, the first
// character of each string flagged in req_tuser. The block takes one character every
// clock cycle while req_tready is high. A result that ends while the output register
// waits on rsp_tready goes into a holding register, so req_tready drops only while a
// second result waits behind the first; it comes straight from that register and never
// depends on rsp_tready. The character that ends the number (NUL or any non-digit of
// the base) loads its result into the output register if free, else into the holding
// register. The rate is set by the accumulator loop: one VALUE_WIDTH by 6 bit multiply
// and add with its overflow check completes every cycle. Base and signed mode are
// sampled on the first character of a string and should be written only while idle.
module ascii_integer_parser #(
   parameter int VALUE_WIDTH  = 64,
   parameter int OFFSET_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tuser,   // [0] start_req

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [VALUE_WIDTH-1:0] value, then 16 bits end_offset, zero padded to whole bytes
   output logic [((VALUE_WIDTH+aip_pkg::OFFSET_OUT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0] rsp_tuser,   // [0] saturated, [1] no_digits

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [aip_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [aip_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int RSP_WIDTH = ((VALUE_WIDTH + aip_pkg::OFFSET_OUT_WIDTH + 7) / 8) * 8;
   localparam int MAC_WIDTH = VALUE_WIDTH + aip_pkg::BASE_WIDTH + 1;
   localparam int OUT_WIDTH = VALUE_WIDTH + aip_pkg::OFFSET_OUT_WIDTH;

   logic [aip_pkg::BASE_WIDTH-1:0] base_select_ff;
   logic                           signed_mode_ff;

   aip_pkg::phase_type             phase_ff, phase_in, eff_phase;
   logic [VALUE_WIDTH-1:0]         acc_ff, acc_in, eff_acc;
   logic [aip_pkg::BASE_WIDTH-1:0] base_ff, base_in, eff_base;
   logic                           neg_ff, neg_in, eff_neg;
   logic [OFFSET_WIDTH-1:0]        pos_ff, pos_in, eff_pos;
   logic                           ovf_ff, ovf_in, eff_ovf;
   logic                           lz_ff, lz_in, eff_lz;
   logic                           msigned_ff, eff_signed;

   logic                 rsp_valid_ff;
   logic [OUT_WIDTH-1:0] rsp_data_ff;
   logic [1:0]           rsp_flags_ff;
   logic                 hold_valid_ff;
   logic [OUT_WIDTH-1:0] hold_data_ff;
   logic [1:0]           hold_flags_ff;
   logic                 out_free;
   logic [OUT_WIDTH-1:0] emit_data;
   logic [1:0]           emit_flags;

   logic [7:0]         ch;
   logic               req_fire;
   aip_pkg::digit_type dig;
   logic is_space, is_plus, is_minus, is_zero, is_x;
   logic lead_like, skip_space, take_sign, take_plus, first_go, first_zero;
   logic lz_step, x_skip, digit_go, digit_ok, consumed, emit, advance;
   logic [aip_pkg::BASE_WIDTH-1:0] digit_base;
   logic [MAC_WIDTH-1:0]           mac;
   logic                           mac_ovf;
   logic [VALUE_WIDTH-1:0]         emit_value;
   logic [OFFSET_WIDTH+aip_pkg::OFFSET_OUT_WIDTH-1:0] pos_ext;
   logic [aip_pkg::OFFSET_OUT_WIDTH-1:0] emit_offset;

   assign ch         = req_tdata;
   assign req_tready = !hold_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_select_ff <= aip_pkg::BASE_RESET;
         signed_mode_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            aip_pkg::CSR_BASE_SELECT: base_select_ff <= csr_wdata;
            aip_pkg::CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A start character restarts the parse from a clean state.
   assign eff_phase  = req_tuser ? aip_pkg::PH_LEAD : phase_ff;
   assign eff_acc    = req_tuser ? '0 : acc_ff;
   assign eff_base   = req_tuser ? base_select_ff : base_ff;
   assign eff_neg    = req_tuser ? 1'b0 : neg_ff;
   assign eff_pos    = req_tuser ? '0 : pos_ff;
   assign eff_ovf    = req_tuser ? 1'b0 : ovf_ff;
   assign eff_lz     = req_tuser ? 1'b0 : lz_ff;
   assign eff_signed = req_tuser ? signed_mode_ff : msigned_ff;

   assign dig      = aip_pkg::char_digit(ch);
   assign is_space = ch == aip_pkg::CH_SPACE || ch == aip_pkg::CH_TAB ||
                     ch == aip_pkg::CH_LF || ch == aip_pkg::CH_CR ||
                     ch == aip_pkg::CH_FF || ch == aip_pkg::CH_VT;
   assign is_plus  = ch == aip_pkg::CH_PLUS;
   assign is_minus = ch == aip_pkg::CH_MINUS;
   assign is_zero  = ch == aip_pkg::CH_ZERO;
   assign is_x     = ch == aip_pkg::CH_LO_X || ch == aip_pkg::CH_UP_X;

   assign lead_like  = eff_phase == aip_pkg::PH_LEAD || eff_phase == aip_pkg::PH_AFTER_SIGN;
   assign skip_space = lead_like && is_space;
   assign take_sign  = eff_phase == aip_pkg::PH_LEAD && eff_signed && (is_plus || is_minus);
   assign take_plus  = (eff_phase == aip_pkg::PH_LEAD && !eff_signed && is_plus) ||
                       (eff_phase == aip_pkg::PH_AFTER_SIGN && is_plus);
   assign first_go   = (lead_like && !skip_space && !take_sign && !take_plus) ||
                       eff_phase == aip_pkg::PH_FIRST;
   assign first_zero = first_go && is_zero &&
                       (eff_base == aip_pkg::BASE_AUTO || eff_base == aip_pkg::BASE_HEX);
   assign lz_step    = eff_phase == aip_pkg::PH_DIGITS && eff_lz;
   assign x_skip     = lz_step && is_x;
   assign digit_go   = (first_go && !first_zero) ||
                       (eff_phase == aip_pkg::PH_DIGITS && !x_skip);
   assign consumed   = eff_phase == aip_pkg::PH_DIGITS;

   always_comb begin
      digit_base = eff_base;
      if (eff_base == aip_pkg::BASE_AUTO) begin
         if (first_go) begin
            digit_base = aip_pkg::BASE_DEC;
         end else if (lz_step) begin
            digit_base = aip_pkg::BASE_OCT;
         end
      end
   end

   assign digit_ok = dig.valid && dig.value < digit_base;
   assign emit     = req_fire && digit_go && !digit_ok;
   assign advance  = skip_space || take_sign || take_plus || first_zero || x_skip ||
                     (digit_go && digit_ok);

   assign mac     = MAC_WIDTH'(eff_acc) * MAC_WIDTH'(digit_base) + MAC_WIDTH'(dig.value);
   assign mac_ovf = |mac[MAC_WIDTH-1:VALUE_WIDTH];

   always_comb begin
      phase_in = eff_phase;
      if (digit_go && !digit_ok) begin
         phase_in = aip_pkg::PH_IDLE;
      end else if (take_sign) begin
         phase_in = aip_pkg::PH_AFTER_SIGN;
      end else if (take_plus) begin
         phase_in = aip_pkg::PH_FIRST;
      end else if (first_zero || x_skip || (digit_go && digit_ok)) begin
         phase_in = aip_pkg::PH_DIGITS;
      end
   end

   always_comb begin
      acc_in  = eff_acc;
      ovf_in  = eff_ovf;
      neg_in  = take_sign ? is_minus : eff_neg;
      lz_in   = first_zero ? 1'b1 : (lz_step ? 1'b0 : eff_lz);
      base_in = eff_base;
      pos_in  = eff_pos;
      if (x_skip) begin
         if (eff_base == aip_pkg::BASE_AUTO) begin
            base_in = aip_pkg::BASE_HEX;
         end
      end else if (digit_go) begin
         base_in = digit_base;
      end
      if (digit_go && digit_ok && !eff_ovf) begin
         if (mac_ovf) begin
            acc_in = '1;
            ovf_in = 1'b1;
         end else begin
            acc_in = mac[VALUE_WIDTH-1:0];
         end
      end
      if (advance && eff_pos != '1) begin
         pos_in = eff_pos + 1'b1;
      end
      pos_ext     = {{aip_pkg::OFFSET_OUT_WIDTH{1'b0}}, eff_pos};
      emit_offset = pos_ext[aip_pkg::OFFSET_OUT_WIDTH-1:0];
      emit_value  = eff_neg ? (~eff_acc + 1'b1) : eff_acc;
      if (eff_signed && !consumed) begin
         emit_value  = '0;
         emit_offset = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= aip_pkg::PH_IDLE;
         ovf_ff     <= 1'b0;
         lz_ff      <= 1'b0;
         msigned_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         ovf_ff     <= ovf_in;
         lz_ff      <= lz_in;
         msigned_ff <= eff_signed;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         acc_ff  <= acc_in;
         base_ff <= base_in;
         neg_ff  <= neg_in;
         pos_ff  <= pos_in;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_data  = {emit_offset, emit_value};
   assign emit_flags = {!consumed, eff_ovf};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (hold_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= emit;
         end
      end else if (emit) begin
         hold_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (hold_valid_ff) begin
            rsp_data_ff  <= hold_data_ff;
            rsp_flags_ff <= hold_flags_ff;
         end else if (emit) begin
            rsp_data_ff  <= emit_data;
            rsp_flags_ff <= emit_flags;
         end
      end else if (emit) begin
         hold_data_ff  <= emit_data;
         hold_flags_ff <= emit_flags;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(rsp_data_ff);
   assign rsp_tuser  = rsp_flags_ff;

   // A new result is only ever loaded by a character transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("result appeared without a character transfer");

   // Emitting a result always returns the parser to idle.
   assert property (@(posedge clock) disable iff (reset)
      emit |=> phase_ff == aip_pkg::PH_IDLE)
      else $error("parser not idle after a result");

   // Saturation pins the accumulator at all ones.
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> acc_ff == {VALUE_WIDTH{1'b1}})
      else $error("overflowed accumulator is not saturated");

   // A pending leading zero only exists while digits are being collected.
   assert property (@(posedge clock) disable iff (reset)
      lz_ff |-> phase_ff == aip_pkg::PH_DIGITS)
      else $error("leading zero flag outside the digit phase");

   // Overflow needs at least one digit, so both flags never show together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_flags_ff[0] && rsp_flags_ff[1]))
      else $error("result both saturated and without digits");

   // The holding register only fills behind a result that is already waiting.
   assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("held result without a result in the output register");

endmodule
